@@ sv/lrht_pkg.sv @@
package lrht_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int HANDLE_WIDTH = 32;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int ACT_W        = 2;
    localparam int IN_TDATA_W   = ((2 * HANDLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((HANDLE_WIDTH + 2 + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_LATEST = 2'd1,
        ACT_SWAP   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        addr;
        logic [HANDLE_WIDTH-1:0] data;
    } mem_wr_t;

endpackage

@@ sv/lrht_mem.sv @@
module lrht_mem
    import lrht_pkg::*;
(
    input  logic                    clk,
    input  mem_wr_t                 wr,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic [HANDLE_WIDTH-1:0] rd_data
);

    logic [HANDLE_WIDTH-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lrht_seq.sv @@
module lrht_seq
    import lrht_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ACT_W-1:0]        in_action,
    input  logic [HANDLE_WIDTH-1:0] in_handle,
    input  logic [HANDLE_WIDTH-1:0] in_replace,
    // result
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HANDLE_WIDTH-1:0] out_handle,
    output logic                    out_success,
    output logic                    out_has_room,
    // table memory
    output mem_wr_t                 mem_wr,
    output logic [IDX_W-1:0]        mem_rd_addr,
    input  logic [HANDLE_WIDTH-1:0] mem_rd_data
);

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;

    action_t                 act_reg, act_next;
    logic [HANDLE_WIDTH-1:0] hv_reg, hv_next;
    logic [HANDLE_WIDTH-1:0] rv_reg, rv_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [HANDLE_WIDTH-1:0] res_handle_reg, res_handle_next;
    logic                    res_ok_reg, res_ok_next;
    logic [HANDLE_WIDTH-1:0] out_handle_reg, out_handle_next;
    logic                    out_ok_reg, out_ok_next;
    logic                    out_room_reg, out_room_next;

    logic    in_fire;
    logic    out_free;
    logic    hit;
    action_t in_act;

    assign in_act   = action_t'(in_action);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // single shared comparator: latest looks for non-null, swap for the compare value
    assign hit = (act_reg == ACT_LATEST) ? (mem_rd_data != '0) : (mem_rd_data == hv_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_act == ACT_ADD || in_act == ACT_CLEAR || cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (hit || left_reg == '0))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        left_next       = left_reg;
        pend_next       = pend_reg;
        act_next        = act_reg;
        hv_next         = hv_reg;
        rv_next         = rv_reg;
        scan_idx_next   = scan_idx_reg;
        pend_idx_next   = pend_idx_reg;
        res_handle_next = res_handle_reg;
        res_ok_next     = res_ok_reg;
        out_handle_next = out_handle_reg;
        out_ok_next     = out_ok_reg;
        out_room_next   = out_room_reg;
        out_valid_next  = out_valid_reg;
        mem_wr          = '0;
        mem_rd_addr     = scan_idx_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    act_next        = in_act;
                    hv_next         = in_handle;
                    rv_next         = in_replace;
                    res_handle_next = '0;
                    res_ok_next     = 1'b0;
                    case (in_act)
                        ACT_ADD:
                        begin
                            if (cnt_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                mem_wr.en       = 1'b1;
                                mem_wr.addr     = cnt_reg[IDX_W-1:0];
                                mem_wr.data     = in_handle;
                                cnt_next        = cnt_reg + 1'b1;
                                res_handle_next = in_handle;
                                res_ok_next     = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            // stale entries are never read past the fill count
                            cnt_next    = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            scan_idx_next = IDX_W'(cnt_reg - 1'b1);
                            left_next     = cnt_reg;
                            pend_next     = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, compare the one issued last cycle
                if (left_reg != '0)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg - 1'b1;
                    left_next     = left_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && hit)
                begin
                    res_ok_next = 1'b1;
                    if (act_reg == ACT_LATEST)
                    begin
                        res_handle_next = mem_rd_data;
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = pend_idx_reg;
                        mem_wr.data = rv_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = res_handle_reg;
                    out_ok_next     = res_ok_reg;
                    out_room_next   = (cnt_reg < CNT_W'(TABLE_DEPTH));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        hv_reg         <= hv_next;
        rv_reg         <= rv_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        res_handle_reg <= res_handle_next;
        res_ok_reg     <= res_ok_next;
        out_handle_reg <= out_handle_next;
        out_ok_reg     <= out_ok_next;
        out_room_reg   <= out_room_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_handle   = out_handle_reg;
    assign out_success  = out_ok_reg;
    assign out_has_room = out_room_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_cnt_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(cnt_reg))
        else $error("fill count changed outside an accepted transaction");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && pend_reg) |-> (CNT_W'(pend_idx_reg) < cnt_reg))
        else $error("scan compared an entry past the fill count");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> (in_fire || (state_reg == ST_SCAN && act_reg == ACT_SWAP)))
        else $error("table written outside add or swap");

    a_finish_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished transaction not presented");

endmodule

@@ sv/latest_request_handle_table.sv @@
// Request handle table. Holds up to TABLE_DEPTH handles (0 = null) appended in
// order. Add (tuser 0) and clear (tuser 3) pass from accept through the finish
// state to the output register. Latest (1) and compare-and-swap (2) scan from
// the newest entry down with one comparator over a registered-read table, one
// entry per cycle. The block takes one transaction at a time; a finished
// result sits in an output register so the next request can be accepted while
// it waits. Clear only resets the fill count.
module latest_request_handle_table
    import lrht_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // handle_value, replace_value
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // handle_out, success, has_room, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    mem_wr_t                 mem_wr;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [HANDLE_WIDTH-1:0] mem_rd_data;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic                    out_success;
    logic                    out_has_room;

    lrht_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_action    (s_axis_tuser),
        .in_handle    (s_axis_tdata[HANDLE_WIDTH-1:0]),
        .in_replace   (s_axis_tdata[2*HANDLE_WIDTH-1:HANDLE_WIDTH]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_handle   (out_handle),
        .out_success  (out_success),
        .out_has_room (out_has_room),
        .mem_wr       (mem_wr),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    lrht_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_has_room, out_success, out_handle});

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import lrht_pkg::*;

    localparam int HW            = HANDLE_WIDTH;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PRESSURE_HOLD = 400;

    typedef struct packed {
        logic [HW-1:0] handle;
        logic          success;
        logic          room;
    } table_reply_t;

    typedef struct packed {
        action_t       act;
        logic [HW-1:0] hv;
        logic [HW-1:0] rv;
        logic          fixed;
        table_reply_t  want;
    } op_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [ACT_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow copy of the handle table
    logic [HW-1:0] shadow_handles [TABLE_DEPTH];
    int            shadow_fill;

    table_reply_t  due_replies [$];
    op_row_t       directed_ops [$];
    int            bad_replies;
    int            replies_seen;

    latest_request_handle_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic table_reply_t apply_table_op(action_t act, logic [HW-1:0] hv,
                                                    logic [HW-1:0] rv);
        table_reply_t res;
        bit           found;
        res   = '0;
        found = 1'b0;
        case (act)
            ACT_ADD:
            begin
                if (shadow_fill < TABLE_DEPTH)
                begin
                    shadow_handles[shadow_fill] = hv;
                    shadow_fill++;
                    res.handle  = hv;
                    res.success = 1'b1;
                end
            end
            ACT_LATEST:
            begin
                for (int i = shadow_fill; i > 0; i--)
                begin
                    if (!found && shadow_handles[i-1] != '0)
                    begin
                        res.handle  = shadow_handles[i-1];
                        res.success = 1'b1;
                        found       = 1'b1;
                    end
                end
            end
            ACT_SWAP:
            begin
                // newest matching entry wins
                for (int i = shadow_fill; i > 0; i--)
                begin
                    if (!found && shadow_handles[i-1] == hv)
                    begin
                        shadow_handles[i-1] = rv;
                        res.success         = 1'b1;
                        found               = 1'b1;
                    end
                end
            end
            default:
            begin
                shadow_fill = 0;
                res.success = 1'b1;
            end
        endcase
        res.room = (shadow_fill < TABLE_DEPTH);
        return res;
    endfunction

    function automatic op_row_t make_row(action_t act, logic [HW-1:0] hv, logic [HW-1:0] rv,
                                         logic fixed, logic [HW-1:0] h, logic s, logic r);
        op_row_t row;
        row.act          = act;
        row.hv           = hv;
        row.rv           = rv;
        row.fixed        = fixed;
        row.want.handle  = h;
        row.want.success = s;
        row.want.room    = r;
        return row;
    endfunction

    function automatic logic [HW-1:0] rand_value();
        logic [HW-1:0] v;
        int            r;
        r = $urandom_range(0, 99);
        v = HW'({$urandom, $urandom});
        if (r < 10)
            v = '0;
        else if (r < 15)
            v = '1;
        else if (r < 40)
            v = HW'($urandom_range(1, 4));    // small pool so duplicates show up
        return v;
    endfunction

    function automatic logic [HW-1:0] pick_compare();
        int r;
        r = $urandom_range(0, 99);
        if (shadow_fill > 0 && r < 60)
            return shadow_handles[$urandom_range(0, shadow_fill - 1)];
        else if (r < 75)
            return '0;
        return rand_value();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_op(action_t act, logic [HW-1:0] hv, logic [HW-1:0] rv,
                           logic fixed, table_reply_t want);
        logic [IN_TDATA_W-1:0] word;
        table_reply_t          pred;
        int                    gap;
        word           = '0;
        word[HW-1:0]   = hv;
        word[2*HW-1:HW] = rv;
        gap            = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = apply_table_op(act, hv, rv);
        due_replies.push_back(fixed ? want : pred);
    endtask

    always @(posedge clk)
    begin : check_reply
        table_reply_t got;
        table_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.handle  = m_axis_tdata[HW-1:0];
            got.success = m_axis_tdata[HW];
            got.room    = m_axis_tdata[HW+1];
            replies_seen++;
            if (due_replies.size() == 0)
            begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("unexpected reply: handle %h success %b room %b",
                             got.handle, got.success, got.room);
            end
            else
            begin
                want = due_replies.pop_front();
                if (got !== want)
                begin
                    bad_replies++;
                    if (bad_replies <= 10)
                        $display("bad reply %0d: want handle %h success %b room %b, got %h %b %b",
                                 replies_seen, want.handle, want.success, want.room,
                                 got.handle, got.success, got.room);
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    initial
    begin : receiver
        int  r;
        int  stall;
        bit  pressure_done;
        m_axis_tready = 1'b0;
        pressure_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!pressure_done && replies_seen >= 150)
            begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge clk);
                pressure_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                stall = 0;
            else if (r < 92)
                stall = $urandom_range(1, 4);
            else
                stall = $urandom_range(15, 60);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("latest_request_handle_table: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        op_row_t row;
        int      sent;
        int      kind;
        int      len;
        int      r;
        bit      first_burst;
        action_t act;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_ADD;
        shadow_fill   = 0;
        bad_replies   = 0;
        replies_seen  = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_handles[i] = '0;

        // directed part
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b1, '0, 1'b0, 1'b1));
        directed_ops.push_back(make_row(ACT_SWAP, '0, 32'h5a5a5a5a, 1'b1, '0, 1'b0, 1'b1));
        directed_ops.push_back(make_row(ACT_ADD, '1, '0, 1'b1, '1, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_ADD, '0, '1, 1'b1, '0, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_SWAP, '0, 32'h12345678, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_LATEST, '1, '1, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_SWAP, 32'hdeadbeef, 32'h1, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_ADD, 32'h1, '0, 1'b1, 32'h1, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_ADD, 32'h1, '0, 1'b1, 32'h1, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_SWAP, 32'h1, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_SWAP, 32'h1, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_SWAP, '1, '1, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_ADD, 32'h80000000, '0, 1'b1, 32'h80000000,
                                        1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_CLEAR, '1, '1, 1'b1, '0, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b1, '0, 1'b0, 1'b1));
        // stale entries past the fill count must stay hidden
        directed_ops.push_back(make_row(ACT_SWAP, '0, 32'h1, 1'b1, '0, 1'b0, 1'b1));
        directed_ops.push_back(make_row(ACT_ADD, '0, '0, 1'b1, '0, 1'b1, 1'b1));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b1, '0, 1'b0, 1'b1));
        directed_ops.push_back(make_row(ACT_SWAP, '0, 32'haaaaaaaa, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_LATEST, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        directed_ops.push_back(make_row(ACT_CLEAR, '0, '0, 1'b1, '0, 1'b1, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
        begin
            row = directed_ops[i];
            send_op(row.act, row.hv, row.rv, row.fixed, row.want);
        end

        // random part in bursts; the first burst runs the table past full
        sent        = 0;
        first_burst = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            kind = first_burst ? 0 : $urandom_range(0, 99);
            if (kind < 25)
            begin
                len = TABLE_DEPTH - shadow_fill + (first_burst ? 2 : $urandom_range(0, 3));
                repeat (len)
                begin
                    send_op(ACT_ADD, rand_value(), HW'({$urandom, $urandom}), 1'b0, '0);
                    sent++;
                end
            end
            else if (kind < 30)
            begin
                send_op(ACT_CLEAR, HW'({$urandom, $urandom}), HW'({$urandom, $urandom}),
                        1'b0, '0);
                sent++;
            end
            else
            begin
                len = $urandom_range(10, 60);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        act = ACT_ADD;
                    else if (r < 60)
                        act = ACT_LATEST;
                    else if (r < 95)
                        act = ACT_SWAP;
                    else
                        act = ACT_CLEAR;
                    if (act == ACT_SWAP)
                        send_op(act, pick_compare(), rand_value(), 1'b0, '0);
                    else if (act == ACT_ADD)
                        send_op(act, rand_value(), HW'({$urandom, $urandom}), 1'b0, '0);
                    else
                        send_op(act, HW'({$urandom, $urandom}), HW'({$urandom, $urandom}),
                                1'b0, '0);
                    sent++;
                end
            end
            first_burst = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (bad_replies == 0 && due_replies.size() == 0)
            $display("latest_request_handle_table: match");
        else
            $display("latest_request_handle_table: mismatch");
        $finish;
    end

endmodule
